FILE: hw/rtl/hbq_pkg.sv
package hbq_pkg;

	localparam int KEY_W     = 32;
	localparam logic [KEY_W-1:0] KEY_BIAS = 32'h8000_0000;
	localparam int DEPTH_DEF = 1024;
	localparam int DEPTH_MAX = 65536;
	// widths sized for the largest supported depth
	localparam int IDX_W     = $clog2(DEPTH_MAX + 1);
	localparam int OFF_W     = IDX_W - 1;
	localparam int LVL_W     = $clog2(IDX_W);

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic {
		OP_INS,
		OP_EXT
	} op_t;

	// item travelling down the chain of levels
	typedef struct packed {
		logic             vld;
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [OFF_W-1:0] off;
	} tok_t;

	// write handed up to the level above
	typedef struct packed {
		logic             vld;
		logic [OFF_W-1:0] off;
		logic [KEY_W-1:0] data;
	} wr_t;

	// broadcast from the sequencer to every level
	typedef struct packed {
		logic [IDX_W-1:0] n;
		logic [LVL_W-1:0] tl;
		logic             fetch;
		logic [OFF_W-1:0] foff;
	} ctl_t;

endpackage

FILE: hw/rtl/hbq_ram.sv
module hbq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                              rdata_a,
	output logic [WIDTH-1:0]                              rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: hw/rtl/hbq_cell.sv
module hbq_cell #(
	parameter int LEVEL = 0,
	parameter int DEPTH = hbq_pkg::DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hbq_pkg::ctl_t           ctl,
	input  hbq_pkg::tok_t           dn_in,
	output hbq_pkg::tok_t           dn_out,
	input  hbq_pkg::wr_t            up_in,
	output hbq_pkg::wr_t            up_out,
	output logic [hbq_pkg::KEY_W-1:0] rd_a,
	output logic                    fin
);

	localparam int NODES  = 1 << LEVEL;
	localparam int LDEPTH = (DEPTH + 1 - NODES < NODES) ? DEPTH + 1 - NODES : NODES;
	localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
	localparam logic [hbq_pkg::LVL_W-1:0] MY_LVL = hbq_pkg::LVL_W'(LEVEL);

	hbq_pkg::tok_t tok_q;
	hbq_pkg::tok_t dn_q;
	hbq_pkg::tok_t dn_d;
	logic          fin_q;
	logic          fin_d;

	logic [hbq_pkg::OFF_W-1:0] addr_a;
	logic [hbq_pkg::OFF_W-1:0] addr_b;
	logic [hbq_pkg::KEY_W-1:0] ra;
	logic [hbq_pkg::KEY_W-1:0] rb;

	logic                      own_we;
	logic [hbq_pkg::OFF_W-1:0] own_off;
	logic [hbq_pkg::KEY_W-1:0] own_data;
	logic                      we;
	logic [hbq_pkg::OFF_W-1:0] waddr;
	logic [hbq_pkg::KEY_W-1:0] wdata;

	logic [hbq_pkg::LVL_W-1:0] sh;
	logic                      pbit;
	logic [hbq_pkg::IDX_W-1:0] lidx;
	logic                      lex;
	logic                      rex;
	logic                      pick_r;
	logic [hbq_pkg::KEY_W-1:0] cv;

	// read addresses come straight off the incoming item, or from foff for a fetch on level tl
	always_comb begin
		if (ctl.fetch && ctl.tl == MY_LVL) begin
			addr_a = ctl.foff;
		end else if (dn_in.op == hbq_pkg::OP_EXT) begin
			addr_a = dn_in.off << 1;
		end else begin
			addr_a = dn_in.off;
		end
		addr_b = (dn_in.off << 1) | hbq_pkg::OFF_W'(1);
	end

	always_comb begin
		dn_d     = '0;
		fin_d    = 1'b0;
		up_out   = '0;
		own_we   = 1'b0;
		own_off  = tok_q.off;
		own_data = tok_q.key;
		sh       = ctl.tl - MY_LVL - hbq_pkg::LVL_W'(1);
		pbit     = ctl.n[sh];
		lidx     = (hbq_pkg::IDX_W'(1) << LEVEL) | (hbq_pkg::IDX_W'(tok_q.off) << 1);
		lex      = lidx <= ctl.n;
		rex      = (lidx + hbq_pkg::IDX_W'(1)) <= ctl.n;
		pick_r   = rex && (rb < ra);
		cv       = pick_r ? rb : ra;
		if (tok_q.vld) begin
			if (tok_q.op == hbq_pkg::OP_INS) begin
				own_we = 1'b1;
				if (ctl.tl == MY_LVL) begin
					fin_d = 1'b1;
				end else begin
					// smaller key stays here, larger one moves on down the path
					own_data   = (tok_q.key <= ra) ? tok_q.key : ra;
					dn_d.vld   = 1'b1;
					dn_d.op    = hbq_pkg::OP_INS;
					dn_d.key   = (tok_q.key <= ra) ? ra : tok_q.key;
					dn_d.off   = (tok_q.off << 1) | hbq_pkg::OFF_W'(pbit);
				end
			end else if (LEVEL == 0) begin
				dn_d = tok_q;
			end else begin
				// off is the parent slot one level up
				up_out.vld = 1'b1;
				up_out.off = tok_q.off;
				if (!lex || tok_q.key <= cv) begin
					up_out.data = tok_q.key;
					fin_d       = 1'b1;
				end else begin
					up_out.data = cv;
					dn_d.vld    = 1'b1;
					dn_d.op     = hbq_pkg::OP_EXT;
					dn_d.key    = tok_q.key;
					dn_d.off    = (tok_q.off << 1) | hbq_pkg::OFF_W'(pick_r);
				end
			end
		end
	end

	always_comb begin
		if (up_in.vld) begin
			we    = 1'b1;
			waddr = up_in.off;
			wdata = up_in.data;
		end else begin
			we    = own_we;
			waddr = own_off;
			wdata = own_data;
		end
	end

	hbq_ram #(
		.WIDTH(hbq_pkg::KEY_W),
		.DEPTH(LDEPTH)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr[LAW-1:0]),
		.wdata  (wdata),
		.raddr_a(addr_a[LAW-1:0]),
		.raddr_b(addr_b[LAW-1:0]),
		.rdata_a(ra),
		.rdata_b(rb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			dn_q  <= '0;
			fin_q <= 1'b0;
		end else begin
			tok_q <= dn_in;
			dn_q  <= dn_d;
			fin_q <= fin_d;
		end
	end

	assign dn_out = dn_q;
	assign fin    = fin_q;
	assign rd_a   = ra;

endmodule

FILE: hw/rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue. Pulse start while busy is low with req_type 0 to insert
// value_in, or 1 to take out the smallest key. Exactly one result per item comes back on
// value_out, status and count_after, marked by a one-cycle done pulse; there is no way to
// hold it off, so capture it on that cycle. The heap is stored one tree level per cell,
// each cell with its own RAM, and an item walks down the chain level by level (registered
// RAM read, then compare and write). Insert on a full heap or extract on an empty one
// answers with an error status in the cycle after start and leaves the contents alone.
module binary_min_heap_queue #(
	parameter int DEPTH = hbq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic signed [31:0]            value_in,
	output logic                          done,
	output logic signed [31:0]            value_out,
	output logic [1:0]                    status,
	output logic [$clog2(DEPTH + 1)-1:0]  count_after
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int NL = CW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_LAUNCH,
		S_RUN
	} state_t;

	function automatic logic [hbq_pkg::LVL_W-1:0] msb_pos(input logic [hbq_pkg::IDX_W-1:0] v);
		logic [hbq_pkg::LVL_W-1:0] p;
		p = '0;
		for (int i = 0; i < hbq_pkg::IDX_W; i++) begin
			if (v[i]) begin
				p = hbq_pkg::LVL_W'(i);
			end
		end
		return p;
	endfunction

	state_t                     state_q;
	hbq_pkg::op_t               op_q;
	logic [CW-1:0]              cnt_q;
	logic [hbq_pkg::IDX_W-1:0]  n_q;
	logic [hbq_pkg::LVL_W-1:0]  tl_q;
	logic [hbq_pkg::OFF_W-1:0]  foff_q;
	hbq_pkg::tok_t              tok0_q;
	logic [hbq_pkg::KEY_W-1:0]  root_q;
	logic                       done_q;
	logic [hbq_pkg::KEY_W-1:0]  value_q;
	logic [1:0]                 status_q;
	logic [CW-1:0]              count_q;

	hbq_pkg::ctl_t              ctl;
	hbq_pkg::tok_t              dn  [NL+1];
	hbq_pkg::wr_t               upw [NL+1];
	logic [hbq_pkg::KEY_W-1:0]  rda [NL];
	logic [NL-1:0]              fin;
	logic [hbq_pkg::KEY_W-1:0]  last_key;

	logic [hbq_pkg::IDX_W-1:0]  cnt_x;
	logic [hbq_pkg::IDX_W-1:0]  ins_n;
	logic [hbq_pkg::LVL_W-1:0]  ins_l;
	logic [hbq_pkg::LVL_W-1:0]  ext_l;

	assign cnt_x = hbq_pkg::IDX_W'(cnt_q);
	assign ins_n = cnt_x + hbq_pkg::IDX_W'(1);
	assign ins_l = msb_pos(ins_n);
	assign ext_l = msb_pos(cnt_x);

	assign ctl.n     = n_q;
	assign ctl.tl    = tl_q;
	assign ctl.fetch = (state_q == S_FETCH);
	assign ctl.foff  = foff_q;

	assign dn[0]   = tok0_q;
	assign upw[NL] = '0;

	genvar l;
	generate
		for (l = 0; l < NL; l++) begin : g_lvl
			hbq_cell #(
				.LEVEL(l),
				.DEPTH(DEPTH)
			) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctl   (ctl),
				.dn_in (dn[l]),
				.dn_out(dn[l+1]),
				.up_in (upw[l+1]),
				.up_out(upw[l]),
				.rd_a  (rda[l]),
				.fin   (fin[l])
			);
		end
	endgenerate

	// last key sits on the level named by tl
	always_comb begin
		last_key = rda[0];
		for (int i = 0; i < NL; i++) begin
			if (tl_q == hbq_pkg::LVL_W'(i)) begin
				last_key = rda[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= hbq_pkg::OP_INS;
			cnt_q    <= '0;
			tok0_q   <= '0;
			done_q   <= 1'b0;
			n_q      <= '0;
			tl_q     <= '0;
			foff_q   <= '0;
			root_q   <= '0;
			value_q  <= '0;
			status_q <= hbq_pkg::ST_OK;
			count_q  <= '0;
		end else begin
			done_q     <= 1'b0;
			tok0_q.vld <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (req_type == 1'b0) begin
							if (cnt_x == hbq_pkg::IDX_W'(DEPTH)) begin
								done_q   <= 1'b1;
								value_q  <= '0;
								status_q <= hbq_pkg::ST_FULL;
								count_q  <= cnt_q;
							end else begin
								op_q       <= hbq_pkg::OP_INS;
								n_q        <= ins_n;
								tl_q       <= ins_l;
								cnt_q      <= cnt_q + CW'(1);
								tok0_q.vld <= 1'b1;
								tok0_q.op  <= hbq_pkg::OP_INS;
								tok0_q.key <= value_in ^ hbq_pkg::KEY_BIAS;
								tok0_q.off <= '0;
								state_q    <= S_RUN;
							end
						end else begin
							if (cnt_q == '0) begin
								done_q   <= 1'b1;
								value_q  <= '0;
								status_q <= hbq_pkg::ST_EMPTY;
								count_q  <= cnt_q;
							end else begin
								op_q    <= hbq_pkg::OP_EXT;
								n_q     <= cnt_x - hbq_pkg::IDX_W'(1);
								tl_q    <= ext_l;
								foff_q  <= hbq_pkg::OFF_W'(cnt_x ^ (hbq_pkg::IDX_W'(1) << ext_l));
								cnt_q   <= cnt_q - CW'(1);
								state_q <= S_FETCH;
							end
						end
					end
				end
				S_FETCH: begin
					state_q <= S_LAUNCH;
				end
				S_LAUNCH: begin
					root_q <= rda[0];
					if (n_q == '0) begin
						done_q   <= 1'b1;
						value_q  <= rda[0] ^ hbq_pkg::KEY_BIAS;
						status_q <= hbq_pkg::ST_OK;
						count_q  <= cnt_q;
						state_q  <= S_IDLE;
					end else begin
						// last key restarts from the root and sinks
						tok0_q.vld <= 1'b1;
						tok0_q.op  <= hbq_pkg::OP_EXT;
						tok0_q.key <= last_key;
						tok0_q.off <= '0;
						state_q    <= S_RUN;
					end
				end
				S_RUN: begin
					if (|fin) begin
						done_q   <= 1'b1;
						value_q  <= (op_q == hbq_pkg::OP_INS) ?
							'0 : root_q ^ hbq_pkg::KEY_BIAS;
						status_q <= hbq_pkg::ST_OK;
						count_q  <= cnt_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign value_out   = value_q;
	assign status      = status_q;
	assign count_after = count_q;

endmodule

FILE: test/tb.sv
module tb;

	localparam int HEAP_DEPTH = 1024;
	localparam int WATCHDOG_LIMIT = 2000;

	class heap_scoreboard;
		typedef struct {
			logic signed [31:0] value;
			logic [1:0]         status;
			logic [10:0]        count;
		} heap_result_t;

		logic signed [31:0] keys[HEAP_DEPTH];
		int unsigned        held;
		heap_result_t       pending_results[$];
		int                 errors;

		function new();
			held = 0;
			errors = 0;
		endfunction

		function void note(logic op, logic signed [31:0] key);
			heap_result_t r;
			int unsigned pos, up, child;
			logic signed [31:0] t;
			r.value = 0;
			r.status = hbq_pkg::ST_OK;
			if (op == hbq_pkg::OP_INS) begin
				if (held >= HEAP_DEPTH)
					r.status = hbq_pkg::ST_FULL;
				else begin
					pos = held;
					keys[pos] = key;
					held++;
					// sift up while not greater than the parent
					while (pos > 0) begin
						up = (pos - 1) / 2;
						if (keys[pos] > keys[up])
							break;
						t = keys[pos]; keys[pos] = keys[up]; keys[up] = t;
						pos = up;
					end
				end
			end else begin
				if (held == 0)
					r.status = hbq_pkg::ST_EMPTY;
				else begin
					r.value = keys[0];
					held--;
					keys[0] = keys[held];
					pos = 0;
					forever begin
						child = 2 * pos + 1;
						if (child >= held)
							break;
						// left child wins a tie
						if (child + 1 < held && keys[child + 1] < keys[child])
							child++;
						if (keys[pos] <= keys[child])
							break;
						t = keys[pos]; keys[pos] = keys[child]; keys[child] = t;
						pos = child;
					end
				end
			end
			r.count = held[10:0];
			pending_results.push_back(r);
		endfunction

		function void check(logic signed [31:0] value, logic [1:0] st, logic [10:0] cnt);
			heap_result_t r;
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
				return;
			end
			r = pending_results.pop_front();
			if (value !== r.value) begin
				$error("value_out: expected %0d, got %0d", r.value, value);
				errors++;
			end
			if (st !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, st);
				errors++;
			end
			if (cnt !== r.count) begin
				$error("count_after: expected %0d, got %0d", r.count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               req_type = 1'b0;
	logic signed [31:0] value_in = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] value_out;
	logic [1:0]         status;
	logic [10:0]        count_after;

	heap_scoreboard heap_sb = new();
	int             quiet_cycles = 0;
	bit             no_idle = 1'b0;

	binary_min_heap_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.value_in(value_in),
		.done(done),
		.value_out(value_out),
		.status(status),
		.count_after(count_after)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				heap_sb.check(value_out, status, count_after);
			if (start && !busy)
				heap_sb.note(req_type, value_in);
			if (done || (start && !busy))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send(logic op, logic signed [31:0] key);
		start <= 1'b1;
		req_type <= op;
		value_in <= key;
		do @(posedge clk); while (busy);
	endtask

	task automatic maybe_idle();
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rand_key();
		// small keys now and then so that equal keys meet in the heap
		if ($urandom_range(0, 3) == 0)
			return $signed($urandom_range(0, 7)) - 4;
		return $urandom;
	endfunction

	task automatic run_mix(int items, int ins_pct);
		repeat (items) begin
			if ($urandom_range(0, 99) < ins_pct)
				send(hbq_pkg::OP_INS, rand_key());
			else
				send(hbq_pkg::OP_EXT, '0);
			maybe_idle();
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (heap_sb.pending_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty extract, key extremes, ties
		send(hbq_pkg::OP_EXT, '0);
		send(hbq_pkg::OP_INS, 32'sh7fff_ffff);
		send(hbq_pkg::OP_INS, 32'sh8000_0000);
		send(hbq_pkg::OP_INS, 0);
		send(hbq_pkg::OP_INS, -1);
		send(hbq_pkg::OP_INS, 1);
		send(hbq_pkg::OP_INS, 0);
		send(hbq_pkg::OP_INS, 32'sh8000_0000);
		repeat (7) send(hbq_pkg::OP_EXT, '0);
		send(hbq_pkg::OP_EXT, '0);
		send(hbq_pkg::OP_INS, 32'sh5555_5555);
		send(hbq_pkg::OP_INS, 32'shaaaa_aaaa);
		send(hbq_pkg::OP_EXT, '0);
		send(hbq_pkg::OP_EXT, '0);

		run_mix(150, 60);

		// hold off until the heap has answered everything
		wait_drained();

		// fill to the top, then knock on a full heap
		while (heap_sb.held < HEAP_DEPTH) begin
			send(hbq_pkg::OP_INS, rand_key());
			maybe_idle();
		end
		repeat (3) send(hbq_pkg::OP_INS, rand_key());

		run_mix(150, 25);
		no_idle = 1'b1;
		run_mix(150, 25);

		wait_drained();
		repeat (40) @(posedge clk);
		if (heap_sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

FILE: binary_min_heap_queue.f
hw/rtl/hbq_pkg.sv
hw/rtl/hbq_ram.sv
hw/rtl/hbq_cell.sv
hw/rtl/binary_min_heap_queue.sv
test/tb.sv
